### design/a2i_pkg.sv
package a2i_pkg;

  // Default saturation point of the character counters.
  localparam int unsigned MAX_CHARS_DEF = 4095;

  localparam int unsigned BASE_W  = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned PROD_W  = VALUE_W + BASE_W;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd36;

  // Register index carried by paddr[2].
  localparam logic REG_NUMBER_BASE = 1'b0;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic [VALUE_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // Commands from the controller, one per controller state.
  typedef struct packed {
    logic load;   // capture the accepted word
    logic step;   // run the parse phase logic, form the product
    logic acc;    // add the digit and check the limit
    logic emit;   // load the result register and clear the parse state
  } a2i_cmd_t;

  typedef struct packed {
    logic fin;       // captured word is the last of its string
    logic out_busy;  // result register still holds a word not taken
  } a2i_sts_t;

  // Digit weight of a character; NO_DIGIT when it is no digit in any base.
  function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = BASE_W'(c - CH_0);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = BASE_W'(c - CH_UP_A) + BASE_DEC;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = BASE_W'(c - CH_LO_A) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

### design/a2i_ctrl.sv
module a2i_ctrl
  import a2i_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  a2i_sts_t sts,
  output a2i_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= sts.fin ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!sts.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.step = (state_r == S_STEP);
    cmd.acc  = (state_r == S_ACC);
    cmd.emit = (state_r == S_EMIT) && !sts.out_busy;
  end

  // A final word always leads to the emit state right after accumulation.
  a_fin_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) && sts.fin |=> (state_r == S_EMIT))
    else $error("final word did not reach the emit state");

endmodule

### design/a2i_dpath.sv
module a2i_dpath
  import a2i_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  a2i_cmd_t             cmd,
  output a2i_sts_t             sts,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 in_is_final,
  input  logic                 cfg_we,
  input  logic [BASE_W-1:0]    cfg_wdata,
  output logic [BASE_W-1:0]    number_base,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VALUE_W-1:0] out_parsed_value,
  output logic [COUNT_W-1:0]   out_consumed_count,
  output logic                 out_overflowed
);

  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHARS);

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  logic [BASE_W-1:0]  nb_r;
  logic [CHAR_W-1:0]  ch_r;
  logic               fin_r;
  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [BASE_W-1:0]  ab_r, ab_nxt;
  logic [VALUE_W-1:0] acc_r;
  logic [CW-1:0]      pos_r, pos_inc;
  logic               ovf_r;
  logic [CW-1:0]      endc_r, endc_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [BASE_W-1:0]  dig_r;
  logic               go_r, go_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  logic [BASE_W-1:0]  dv;
  logic               is_sp;
  logic               start;
  logic               try_dig;
  logic               try_ok;
  logic [BASE_W-1:0]  try_base;
  logic [PROD_W-1:0]  sum;
  logic [VALUE_W-1:0] value_nxt;
  logic [31:0]        endc_ext;

  assign dv      = digit_value(ch_r);
  assign is_sp   = (ch_r == CH_SPACE) || (ch_r >= CH_TAB && ch_r <= CH_CR);
  assign pos_inc = (pos_r >= CNT_MAX) ? CNT_MAX : pos_r + 1'b1;

  // Phase logic for one character; the accumulator update follows in the accumulate state.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    ab_nxt    = ab_r;
    endc_nxt  = endc_r;
    start     = 1'b0;
    try_dig   = 1'b0;
    try_base  = ab_r;
    try_ok    = 1'b0;
    unique case (phase_r)
      PH_WS: begin
        if (is_sp) begin
          phase_nxt = PH_WS;
        end else if (ch_r == CH_PLUS) begin
          phase_nxt = PH_SIGNED;
        end else if (ch_r == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGNED: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (ch_r == CH_LO_X || ch_r == CH_UP_X) begin
          phase_nxt = PH_ZEROX;
        end else begin
          try_base = (nb_r == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          ab_nxt   = try_base;
          try_dig  = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (dv < BASE_HEX) begin
          try_base = BASE_HEX;
          ab_nxt   = BASE_HEX;
          try_dig  = 1'b1;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DIGITS: begin
        try_dig = 1'b1;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // A leading zero in auto or hex mode may still open a 0x prefix.
    if (start) begin
      if ((nb_r == BASE_AUTO || nb_r == BASE_HEX) && ch_r == CH_0) begin
        endc_nxt  = pos_inc;
        phase_nxt = PH_ZERO;
      end else begin
        try_base = (nb_r == BASE_AUTO) ? BASE_DEC : nb_r;
        ab_nxt   = try_base;
        try_dig  = 1'b1;
      end
    end

    if (try_dig) begin
      try_ok = (try_base >= BASE_MIN) && (try_base <= BASE_MAX) && (dv < try_base);
      if (try_ok) begin
        endc_nxt  = pos_inc;
        phase_nxt = PH_DIGITS;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
    go_nxt = try_dig && try_ok && !ovf_r;
  end

  assign sum       = prod_r + PROD_W'(dig_r);
  assign value_nxt = ovf_r ? (neg_r ? SAT_NEG : SAT_POS)
                           : (neg_r ? (~acc_r + 1'b1) : acc_r);
  assign endc_ext  = 32'(endc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r        <= BASE_RESET;
      phase_r     <= PH_WS;
      neg_r       <= 1'b0;
      ab_r        <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      endc_r      <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        nb_r <= cfg_wdata;
      end
      if (cmd.step) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        ab_r    <= ab_nxt;
        endc_r  <= endc_nxt;
        pos_r   <= pos_inc;
        go_r    <= go_nxt;
      end
      if (cmd.acc && go_r) begin
        if (sum > PROD_W'(SAT_POS)) begin
          ovf_r <= 1'b1;
        end else begin
          acc_r <= sum[VALUE_W-1:0];
        end
      end
      if (cmd.emit) begin
        phase_r <= PH_WS;
        neg_r   <= 1'b0;
        ab_r    <= '0;
        acc_r   <= '0;
        pos_r   <= '0;
        ovf_r   <= 1'b0;
        endc_r  <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_char_code;
      fin_r <= in_is_final;
    end
    if (cmd.step) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(try_base);
      dig_r  <= dv;
    end
    if (cmd.emit) begin
      out_value_r <= value_nxt;
      out_count_r <= endc_ext[COUNT_W-1:0];
      out_ovf_r   <= ovf_r;
    end
  end

  assign sts.fin      = fin_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign number_base        = nb_r;
  assign out_valid          = out_valid_r;
  assign out_parsed_value   = out_value_r;
  assign out_consumed_count = out_count_r;
  assign out_overflowed     = out_ovf_r;

  a_endc_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    endc_r <= pos_r)
    else $error("consumed count ran ahead of the character position");

  a_digits_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIGITS) |-> (endc_r != '0))
    else $error("digit phase with an empty consumed count");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> (out_value_r == SAT_POS) || (out_value_r == SAT_NEG))
    else $error("overflowed result is not saturated");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && (pos_r == '0) && !ovf_r)
    else $error("emit did not present a result and clear the parse state");

endmodule

### design/ascii_to_integer_parser_unit.sv
// Each character word passes through the controller states accept, phase decode with the
// accumulator times base product, then add and limit check; the result of a final
// character then goes through the emit state, which loads the result register.
// A new character is accepted only after the last one is through, using the
// single shared 64 by 6 bit multiplier; a stalled result register holds only final words.
// Reset (rst_n, synchronous, active low) clears the parse state and sets number_base to 10.
module ascii_to_integer_parser_unit
  import a2i_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
)(
  input  logic                      clk,
  input  logic                      rst_n,
  // Character input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAR_W-1:0]         in_char_code,
  input  logic                      in_is_final,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_parsed_value,
  output logic [COUNT_W-1:0]        out_consumed_count,
  output logic                      out_overflowed,
  // APB configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  a2i_cmd_t          cmd;
  a2i_sts_t          sts;
  logic              cfg_we;
  logic [BASE_W-1:0] number_base;

  // The only register is number_base at byte address 0; paddr[2] selects the
  // register word and the byte offset bits are ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NUMBER_BASE);
  assign prdata = (paddr[2] == REG_NUMBER_BASE) ? APB_DW'(number_base) : '0;

  // The controller sequences each word through capture, step and accumulate,
  // and waits on a busy result register before emitting a final result.
  a2i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the parse phase, the accumulator, the counters and the
  // result register that decouples the result channel from the input side.
  a2i_dpath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_char_code       (in_char_code),
    .in_is_final        (in_is_final),
    .cfg_we             (cfg_we),
    .cfg_wdata          (pwdata[BASE_W-1:0]),
    .number_base        (number_base),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parsed_value   (out_parsed_value),
    .out_consumed_count (out_consumed_count),
    .out_overflowed     (out_overflowed)
  );

endmodule
